FILE: rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and timing constants of the one-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

	// Item codes on req_type.
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_RESET = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// Operation in progress. The codes match the command codes.
	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_LOW     = 2'd0,
		PH_RELEASE = 2'd1,
		PH_RECOVER = 2'd2
	} phase_t;

	localparam int unsigned TICK_W = 9;

	// Phase lengths in ticks.
	localparam logic [TICK_W-1:0] LEN_RST_LOW   = 9'd480;
	localparam logic [TICK_W-1:0] LEN_RST_REL   = 9'd500;
	localparam logic [TICK_W-1:0] LEN_W1_LOW    = 9'd6;
	localparam logic [TICK_W-1:0] LEN_W1_REL    = 9'd64;
	localparam logic [TICK_W-1:0] LEN_W0_LOW    = 9'd60;
	localparam logic [TICK_W-1:0] LEN_W0_REL    = 9'd10;
	localparam logic [TICK_W-1:0] LEN_RD_LOW    = 9'd2;
	localparam logic [TICK_W-1:0] LEN_RD_SAMPLE = 9'd10;
	localparam logic [TICK_W-1:0] LEN_RD_REC    = 9'd50;

	localparam logic [2:0] LAST_BIT = 3'd7;

	// One result item as produced by the step logic.
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       op_done;
		logic       presence;
		logic [7:0] read_data;
		logic       cmd_rejected;
	} result_t;

endpackage

FILE: rtl/owbm_step.sv
// ----------------------------------------------------------------------------
// owbm_step
// Bus state registers and the single-pass update for one tick or command.
// ----------------------------------------------------------------------------
module owbm_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  owbm_pkg::req_t      req_type,
	input  logic [7:0]          data_byte,
	input  logic                bus_level,
	output owbm_pkg::result_t   res
);
	import owbm_pkg::*;

	op_t                op_q, op_d;
	phase_t             phase_q, phase_d;
	logic [TICK_W-1:0]  tick_q, tick_d;
	logic [2:0]         bit_q, bit_d;
	logic [7:0]         shift_q, shift_d;
	logic               pres_q, pres_d;
	logic [7:0]         rdres_q, rdres_d;

	logic [TICK_W-1:0]  len;
	logic [TICK_W-1:0]  count;
	logic               reached;
	logic               drive_now;
	logic               slot_end;
	logic               done;
	logic               rejected;
	logic               drive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_IDLE;
			phase_q <= PH_LOW;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			rdres_q <= '0;
		end else if (commit) begin
			op_q    <= op_d;
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			rdres_q <= rdres_d;
		end
	end

	// Length of the current phase; write slots depend on the bit being sent.
	always_comb begin
		case (op_q)
			OP_RESET: len = (phase_q == PH_LOW) ? LEN_RST_LOW : LEN_RST_REL;
			OP_WRITE: begin
				if (phase_q == PH_LOW)
					len = shift_q[0] ? LEN_W1_LOW : LEN_W0_LOW;
				else
					len = shift_q[0] ? LEN_W1_REL : LEN_W0_REL;
			end
			default: begin
				case (phase_q)
					PH_LOW:     len = LEN_RD_LOW;
					PH_RELEASE: len = LEN_RD_SAMPLE;
					default:    len = LEN_RD_REC;
				endcase
			end
		endcase
	end

	assign count     = tick_q + TICK_W'(1);
	assign reached   = (count >= len);
	assign drive_now = (op_q != OP_IDLE) && (phase_q == PH_LOW);

	always_comb begin
		op_d     = op_q;
		phase_d  = phase_q;
		tick_d   = tick_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		pres_d   = pres_q;
		rdres_d  = rdres_q;
		slot_end = 1'b0;
		done     = 1'b0;
		rejected = 1'b0;
		drive    = drive_now;

		if (req_type == REQ_TICK) begin
			if (op_q != OP_IDLE) begin
				if (op_q == OP_RESET && phase_q == PH_RELEASE && !bus_level)
					pres_d = 1'b1;
				if (op_q == OP_READ && phase_q == PH_RELEASE && reached)
					shift_d = {bus_level, shift_q[7:1]};

				if (!reached) begin
					tick_d = count;
				end else begin
					tick_d = '0;
					case (op_q)
						OP_RESET: begin
							if (phase_q == PH_LOW) begin
								phase_d = PH_RELEASE;
							end else begin
								op_d    = OP_IDLE;
								phase_d = PH_LOW;
								done    = 1'b1;
							end
						end
						OP_WRITE: begin
							if (phase_q == PH_LOW)
								phase_d = PH_RELEASE;
							else
								slot_end = 1'b1;
						end
						default: begin
							case (phase_q)
								PH_LOW:     phase_d = PH_RELEASE;
								PH_RELEASE: phase_d = PH_RECOVER;
								default:    slot_end = 1'b1;
							endcase
						end
					endcase

					if (slot_end) begin
						phase_d = PH_LOW;
						if (op_q == OP_WRITE)
							shift_d = {1'b0, shift_q[7:1]};
						if (bit_q >= LAST_BIT) begin
							// The recovery phase leaves the shift register untouched,
							// so the assembled byte is the registered value.
							if (op_q == OP_READ)
								rdres_d = shift_q;
							op_d  = OP_IDLE;
							bit_d = '0;
							done  = 1'b1;
						end else begin
							bit_d = bit_q + 3'd1;
						end
					end
				end
			end
		end else if (op_q != OP_IDLE) begin
			rejected = 1'b1;
		end else begin
			op_d    = op_t'(req_type);
			phase_d = PH_LOW;
			tick_d  = '0;
			bit_d   = '0;
			shift_d = (req_type == REQ_WRITE) ? data_byte : 8'd0;
			if (req_type == REQ_RESET)
				pres_d = 1'b0;
			drive   = 1'b1;
		end
	end

	assign res.drive_low    = drive;
	assign res.busy_res     = (op_d != OP_IDLE);
	assign res.op_done      = done;
	assign res.presence     = pres_d;
	assign res.read_data    = rdres_d;
	assign res.cmd_rejected = rejected;

`ifndef SYNTHESIS
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res.op_done) |=> (op_q == OP_IDLE))
		else $error("operation still active after completion");

	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res.cmd_rejected) |=> ($stable(op_q) && $stable(tick_q)
			&& $stable(bit_q) && $stable(shift_q)))
		else $error("rejected command changed the bus state");

	a_tick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < LEN_RST_REL)
		else $error("tick counter ran past the longest phase");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == OP_IDLE) |-> (bit_q == 3'd0 && phase_q == PH_LOW && tick_q == '0))
		else $error("idle master holds leftover slot state");
`endif

endmodule

FILE: rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Open-drain one-wire bus master driven by one-microsecond tick items.
// ----------------------------------------------------------------------------
// Every item, tick or command, is taken into an input register, then run
// through the single-pass bus state update and written to the result
// register when that register can advance. The block accepts one item per
// clock cycle while the result is not stalled. A stalled result holds the
// result register, and the input register then holds the next item.
module one_wire_bus_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	input  logic       bus_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       drive_low,
	output logic       busy_res,
	output logic       op_done,
	output logic       presence,
	output logic [7:0] read_data,
	output logic       cmd_rejected
);
	import owbm_pkg::*;

	logic       valid_s1;
	req_t       req_s1;
	logic [7:0] data_s1;
	logic       bus_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	logic       advance;
	logic       commit;

	assign advance  = !out_valid_q || !out_stall;
	assign commit   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1  <= req_t'(req_type);
			data_s1 <= data_byte;
			bus_s1  <= bus_level;
		end
	end

	owbm_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.req_type  (req_s1),
		.data_byte (data_s1),
		.bus_level (bus_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign drive_low    = res_q.drive_low;
	assign busy_res     = res_q.busy_res;
	assign op_done      = res_q.op_done;
	assign presence     = res_q.presence;
	assign read_data    = res_q.read_data;
	assign cmd_rejected = res_q.cmd_rejected;

endmodule
